>>> design/dtq_pkg.sv
// Package for the deadline timer queue: sizes, codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package dtq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int TIME_W   = 48;
  localparam int OWNER_W  = 16;
  localparam int HANDLE_W = 4;
  localparam int KIND_W   = 3;
  localparam int MODE_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARM_REL = 2'd0,
    MODE_ARM_ABS = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_TICK    = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ARMED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_NONE_DUE  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ARM_SCAN,
    ST_CAN_SCAN,
    ST_TICK,
    ST_FULL,
    ST_NOTF
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_INSERT,
    CMD_CANCEL,
    CMD_POP,
    CMD_FULL,
    CMD_NOTFOUND,
    CMD_NONEDUE
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  handle_valid;
    logic  scan_more;
    logic  scan_hit;
    logic  head_due;
    logic  pop_last;
    logic  popped;
    logic  out_free;
  } status_t;

endpackage

>>> design/dtq_in_if.sv
// Input channel of the deadline timer queue: valid/ready plus item fields.
// Depends on dtq_pkg.
interface dtq_in_if;
  logic                         valid;
  logic                         ready;
  logic [dtq_pkg::MODE_W-1:0]   mode;
  logic [dtq_pkg::TIME_W-1:0]   now_us;
  logic [dtq_pkg::TIME_W-1:0]   amount_us;
  logic [dtq_pkg::OWNER_W-1:0]  owner_id;
  logic [dtq_pkg::HANDLE_W-1:0] cancel_handle;

  modport source (output valid, mode, now_us, amount_us, owner_id, cancel_handle,
                  input ready);
  modport sink   (input valid, mode, now_us, amount_us, owner_id, cancel_handle,
                  output ready);
endinterface

>>> design/dtq_out_if.sv
// Result channel of the deadline timer queue: valid/ready plus result fields.
// Depends on dtq_pkg.
interface dtq_out_if;
  logic                         valid;
  logic                         ready;
  logic [dtq_pkg::KIND_W-1:0]   kind;
  logic [dtq_pkg::HANDLE_W-1:0] slot_handle;
  logic [dtq_pkg::OWNER_W-1:0]  expired_owner;
  logic [dtq_pkg::TIME_W-1:0]   entry_deadline;
  logic [dtq_pkg::TIME_W-1:0]   next_deadline;
  logic [dtq_pkg::CNT_W-1:0]    pending_count;
  logic                         last;

  modport source (output valid, kind, slot_handle, expired_owner, entry_deadline,
                  next_deadline, pending_count, last, input ready);
  modport sink   (input valid, kind, slot_handle, expired_owner, entry_deadline,
                  next_deadline, pending_count, last, output ready);
endinterface

>>> design/dtq_ctrl.sv
// Controller FSM of the deadline timer queue: sequences scan, insert,
// remove and expiry steps. Depends on dtq_pkg.
module dtq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dtq_pkg::status_t status_i,
  output dtq_pkg::cmd_t    cmd_o
);

  dtq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = dtq_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      dtq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = dtq_pkg::CMD_LOAD;
          state_d  = dtq_pkg::ST_DECIDE;
        end
      end
      dtq_pkg::ST_DECIDE: begin
        case (status_i.mode)
          dtq_pkg::MODE_ARM_REL, dtq_pkg::MODE_ARM_ABS: begin
            state_d = status_i.full ? dtq_pkg::ST_FULL : dtq_pkg::ST_ARM_SCAN;
          end
          dtq_pkg::MODE_CANCEL: begin
            state_d = status_i.handle_valid ? dtq_pkg::ST_CAN_SCAN : dtq_pkg::ST_NOTF;
          end
          default: begin
            state_d = dtq_pkg::ST_TICK;
          end
        endcase
      end
      dtq_pkg::ST_ARM_SCAN: begin
        if (status_i.scan_more) begin
          cmd_o.op = dtq_pkg::CMD_STEP;
        end else if (status_i.out_free) begin
          cmd_o.op = dtq_pkg::CMD_INSERT;
          state_d  = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_CAN_SCAN: begin
        if (!status_i.scan_hit) begin
          cmd_o.op = dtq_pkg::CMD_STEP;
        end else if (status_i.out_free) begin
          cmd_o.op = dtq_pkg::CMD_CANCEL;
          state_d  = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_TICK: begin
        if (status_i.out_free) begin
          if (status_i.head_due) begin
            cmd_o.op = dtq_pkg::CMD_POP;
            if (status_i.pop_last) begin
              state_d = dtq_pkg::ST_IDLE;
            end
          end else if (!status_i.popped) begin
            cmd_o.op = dtq_pkg::CMD_NONEDUE;
            state_d  = dtq_pkg::ST_IDLE;
          end else begin
            state_d = dtq_pkg::ST_IDLE;
          end
        end
      end
      dtq_pkg::ST_FULL: begin
        if (status_i.out_free) begin
          cmd_o.op = dtq_pkg::CMD_FULL;
          state_d  = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_NOTF: begin
        if (status_i.out_free) begin
          cmd_o.op = dtq_pkg::CMD_NOTFOUND;
          state_d  = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/dtq_datapath.sv
// Datapath of the deadline timer queue: sorted entry rows, slot valid bits,
// operand registers and the result register. Depends on dtq_pkg.
module dtq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtq_pkg::cmd_t                  cmd_i,
  output dtq_pkg::status_t               status_o,
  input  logic [dtq_pkg::MODE_W-1:0]     mode_i,
  input  logic [dtq_pkg::TIME_W-1:0]     now_i,
  input  logic [dtq_pkg::TIME_W-1:0]     amount_i,
  input  logic [dtq_pkg::OWNER_W-1:0]    owner_i,
  input  logic [dtq_pkg::HANDLE_W-1:0]   handle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dtq_pkg::KIND_W-1:0]     kind_o,
  output logic [dtq_pkg::HANDLE_W-1:0]   slot_o,
  output logic [dtq_pkg::OWNER_W-1:0]    owner_o,
  output logic [dtq_pkg::TIME_W-1:0]     entry_dl_o,
  output logic [dtq_pkg::TIME_W-1:0]     next_dl_o,
  output logic [dtq_pkg::CNT_W-1:0]      count_o,
  output logic                           last_o
);

  localparam int D  = dtq_pkg::DEPTH;
  localparam int IW = dtq_pkg::IDX_W;
  localparam int CW = dtq_pkg::CNT_W;
  localparam int TW = dtq_pkg::TIME_W;

  // sorted rows, position 0 is the earliest deadline
  logic [TW-1:0]                  row_dl_q  [D];
  logic [IW-1:0]                  row_slot_q[D];
  logic [dtq_pkg::OWNER_W-1:0]    row_own_q [D];
  logic [D-1:0]                   valid_q;
  logic [CW-1:0]                  count_q;

  dtq_pkg::mode_e                 mode_q;
  logic [TW-1:0]                  now_q;
  logic [TW-1:0]                  arg_dl_q;
  logic [dtq_pkg::OWNER_W-1:0]    owner_q;
  logic [dtq_pkg::HANDLE_W-1:0]   handle_q;
  logic [CW-1:0]                  pos_q;
  logic                           popped_q;

  logic [TW:0]                    sum;
  logic [TW-1:0]                  load_dl;
  logic [IW-1:0]                  pos_idx;
  logic [IW-1:0]                  free_slot;
  logic                           more_than_one;
  logic                           emit;
  logic [dtq_pkg::KIND_W-1:0]     kind_d;
  logic [dtq_pkg::HANDLE_W-1:0]   slot_d;
  logic [dtq_pkg::OWNER_W-1:0]    own_d;
  logic [TW-1:0]                  edl_d, ndl_d;
  logic [CW-1:0]                  cnt_d;
  logic                           last_d;

  assign sum     = {1'b0, now_i} + {1'b0, amount_i};
  assign load_dl = (dtq_pkg::mode_e'(mode_i) == dtq_pkg::MODE_ARM_REL)
                   ? (sum[TW] ? {TW{1'b1}} : sum[TW-1:0]) : amount_i;
  assign pos_idx = pos_q[IW-1:0];
  assign more_than_one = count_q > CW'(1);

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = IW'(i);
    end
  end

  always_comb begin
    status_o.mode         = mode_q;
    status_o.full         = count_q == CW'(D);
    status_o.handle_valid = valid_q[IW'(handle_q)];
    status_o.scan_more    = (pos_q < count_q) && (row_dl_q[pos_idx] <= arg_dl_q);
    status_o.scan_hit     = row_slot_q[pos_idx] == IW'(handle_q);
    status_o.head_due     = (count_q != '0) && (row_dl_q[0] <= now_q);
    status_o.pop_last     = !(more_than_one && (row_dl_q[1] <= now_q));
    status_o.popped       = popped_q;
    status_o.out_free     = !out_valid_o || out_ready_i;
  end

  // result fields for the command at hand
  always_comb begin
    emit   = 1'b1;
    kind_d = dtq_pkg::KIND_NONE_DUE;
    slot_d = '0;
    own_d  = '0;
    edl_d  = '0;
    ndl_d  = (count_q != '0) ? row_dl_q[0] : '0;
    cnt_d  = count_q;
    last_d = 1'b1;
    case (cmd_i.op)
      dtq_pkg::CMD_INSERT: begin
        kind_d = dtq_pkg::KIND_ARMED;
        slot_d = dtq_pkg::HANDLE_W'(free_slot);
        own_d  = owner_q;
        edl_d  = arg_dl_q;
        ndl_d  = (pos_q == '0) ? arg_dl_q : row_dl_q[0];
        cnt_d  = count_q + CW'(1);
      end
      dtq_pkg::CMD_CANCEL: begin
        kind_d = dtq_pkg::KIND_CANCELLED;
        slot_d = handle_q;
        own_d  = row_own_q[pos_idx];
        edl_d  = row_dl_q[pos_idx];
        ndl_d  = !more_than_one ? '0 : ((pos_q == '0) ? row_dl_q[1] : row_dl_q[0]);
        cnt_d  = count_q - CW'(1);
      end
      dtq_pkg::CMD_POP: begin
        kind_d = dtq_pkg::KIND_EXPIRED;
        slot_d = dtq_pkg::HANDLE_W'(row_slot_q[0]);
        own_d  = row_own_q[0];
        edl_d  = row_dl_q[0];
        ndl_d  = more_than_one ? row_dl_q[1] : '0;
        cnt_d  = count_q - CW'(1);
        last_d = status_o.pop_last;
      end
      dtq_pkg::CMD_FULL: begin
        kind_d = dtq_pkg::KIND_FULL;
        edl_d  = arg_dl_q;
      end
      dtq_pkg::CMD_NOTFOUND: begin
        kind_d = dtq_pkg::KIND_NOT_FOUND;
        slot_d = handle_q;
      end
      dtq_pkg::CMD_NONEDUE: begin
        kind_d = dtq_pkg::KIND_NONE_DUE;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      popped_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_o <= 1'b1;
        count_q     <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (cmd_i.op)
        dtq_pkg::CMD_LOAD: begin
          pos_q    <= '0;
          popped_q <= 1'b0;
        end
        dtq_pkg::CMD_STEP:   pos_q <= pos_q + CW'(1);
        dtq_pkg::CMD_INSERT: valid_q[free_slot] <= 1'b1;
        dtq_pkg::CMD_CANCEL: valid_q[IW'(handle_q)] <= 1'b0;
        dtq_pkg::CMD_POP: begin
          valid_q[row_slot_q[0]] <= 1'b0;
          popped_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers: operands, rows and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dtq_pkg::CMD_LOAD) begin
      mode_q   <= dtq_pkg::mode_e'(mode_i);
      now_q    <= now_i;
      arg_dl_q <= load_dl;
      owner_q  <= owner_i;
      handle_q <= handle_i;
    end
    if (emit) begin
      kind_o     <= kind_d;
      slot_o     <= slot_d;
      owner_o    <= own_d;
      entry_dl_o <= edl_d;
      next_dl_o  <= ndl_d;
      count_o    <= cnt_d;
      last_o     <= last_d;
    end
    for (int i = 0; i < D; i++) begin
      case (cmd_i.op)
        dtq_pkg::CMD_INSERT: begin
          if (CW'(i) == pos_q) begin
            row_dl_q[i]   <= arg_dl_q;
            row_slot_q[i] <= free_slot;
            row_own_q[i]  <= owner_q;
          end else if (i > 0 && CW'(i) > pos_q) begin
            row_dl_q[i]   <= row_dl_q[i-1];
            row_slot_q[i] <= row_slot_q[i-1];
            row_own_q[i]  <= row_own_q[i-1];
          end
        end
        dtq_pkg::CMD_CANCEL, dtq_pkg::CMD_POP: begin
          if (i < D - 1 && (cmd_i.op == dtq_pkg::CMD_POP || CW'(i) >= pos_q)) begin
            row_dl_q[i]   <= row_dl_q[i+1];
            row_slot_q[i] <= row_slot_q[i+1];
            row_own_q[i]  <= row_own_q[i+1];
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(D)) else $error("entry count beyond depth");
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q)) else $error("valid bits disagree with count");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o) else $error("result lost");
`endif

endmodule

>>> design/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_in_if, dtq_out_if, dtq_ctrl and dtq_datapath.

// Sorted timer queue of 16 entries. One input item is taken at a time; ready
// is high only while the controller is idle. An arm walks the sorted rows
// linearly, one position per cycle, past every pending entry with a deadline
// not later than the new one; a cancel walks the rows to the entry's position;
// a tick pops the expired entries one by one, with a result for each, or gives
// a none-due result when nothing is due. Each result lands in an output
// register, so the next item can be taken while the last result of the
// previous one still waits. Relative arms saturate at the largest 48-bit time.
// Ties in deadline keep arrival order.
module deadline_timer_queue_top (
  input logic     clk_i,
  input logic     rst_ni,
  dtq_in_if.sink  in_i,
  dtq_out_if.source out_o
);

  dtq_pkg::cmd_t    cmd;
  dtq_pkg::status_t status;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // a transfer on the input channel loads the operand registers
  dtq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (in_i.mode),
    .now_i       (in_i.now_us),
    .amount_i    (in_i.amount_us),
    .owner_i     (in_i.owner_id),
    .handle_i    (in_i.cancel_handle),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .kind_o      (out_o.kind),
    .slot_o      (out_o.slot_handle),
    .owner_o     (out_o.expired_owner),
    .entry_dl_o  (out_o.entry_deadline),
    .next_dl_o   (out_o.next_deadline),
    .count_o     (out_o.pending_count),
    .last_o      (out_o.last)
  );

endmodule
